[hdl/cbm_pkg.sv]
// Shared constants, types and helper functions of the cartridge bank mapper.
package cbm_pkg;

   localparam int RAM_BANKS_DEF  = 4;
   localparam int RAM_BANK_BYTES = 8192;
   localparam int BANK_OFS_W     = 13;
   localparam int ADDR_W         = 16;
   localparam int DATA_W         = 8;
   localparam int ROM_ADDR_W     = 21;
   localparam int ROM_BANK_W     = 7;
   localparam int ROM_LOW_W      = 5;
   localparam int RAM_BANK_W     = 2;
   localparam int ROM_OFS_W      = 14;
   localparam int TARGET_W       = 2;
   localparam int REGION_W       = 3;

   // Bus access kinds
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // Result kinds
   localparam logic [TARGET_W-1:0] TARGET_NONE = 2'd0;
   localparam logic [TARGET_W-1:0] TARGET_ROM  = 2'd1;
   localparam logic [TARGET_W-1:0] TARGET_RAM  = 2'd2;

   // 8 KB bus regions, decoded from address bits 15:13
   localparam logic [REGION_W-1:0] REGION_RAM_ENABLE = 3'd0;
   localparam logic [REGION_W-1:0] REGION_ROM_BANK_LO = 3'd1;
   localparam logic [REGION_W-1:0] REGION_ROM_BANK_HI = 3'd2;
   localparam logic [REGION_W-1:0] REGION_MODE        = 3'd3;
   localparam logic [REGION_W-1:0] REGION_VIDEO       = 3'd4;
   localparam logic [REGION_W-1:0] REGION_RAM         = 3'd5;

   localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

   typedef struct packed {
      logic [TARGET_W-1:0]   target;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic                  ram_rd;
   } decode_type;

   // Reduce the RAM bank register modulo the number of fitted banks.
   function automatic logic [RAM_BANK_W-1:0] fold_ram_bank(
      input logic [RAM_BANK_W-1:0] bank,
      input int unsigned           banks
   );
      logic [RAM_BANK_W-1:0] b;
      b = bank;
      for (int i = 0; i < 3; i++) begin
         if (32'(b) >= banks) begin
            b = b - RAM_BANK_W'(banks);
         end
      end
      return b;
   endfunction

endpackage

[hdl/cbm_if.sv]
// Request and response channel interfaces of the cartridge bank mapper.
interface cbm_req_if;
   logic                      valid;
   logic                      ready;
   logic                      func;
   logic [cbm_pkg::ADDR_W-1:0] bus_address;
   logic [cbm_pkg::DATA_W-1:0] write_data;

   modport source (output valid, func, bus_address, write_data, input ready);
   modport sink (input valid, func, bus_address, write_data, output ready);
   modport monitor (input valid, ready, func, bus_address, write_data);
endinterface

interface cbm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cbm_pkg::TARGET_W-1:0]   target;
   logic [cbm_pkg::ROM_ADDR_W-1:0] rom_address;
   logic [cbm_pkg::DATA_W-1:0]     read_data;

   modport source (output valid, target, rom_address, read_data, input ready);
   modport sink (input valid, target, rom_address, read_data, output ready);
   modport monitor (input valid, ready, target, rom_address, read_data);
endinterface

[hdl/cbm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module cbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/cbm_ctrl.sv]
// Bank registers, bus access decode and RAM clearing sweep.
module cbm_ctrl #(
   parameter int RAM_BANKS = cbm_pkg::RAM_BANKS_DEF,
   parameter int RAM_AW    = 15
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         accept,
   input  logic                         func,
   input  logic [cbm_pkg::ADDR_W-1:0]    bus_address,
   input  logic [cbm_pkg::DATA_W-1:0]    write_data,
   output cbm_pkg::decode_type          decode,
   output logic                         clr_busy,
   output logic                         ram_wr_en,
   output logic [RAM_AW-1:0]            ram_wr_addr,
   output logic [cbm_pkg::DATA_W-1:0]    ram_wr_data,
   output logic                         ram_rd_en,
   output logic [RAM_AW-1:0]            ram_rd_addr
);

   localparam int RAM_DEPTH = RAM_BANKS * cbm_pkg::RAM_BANK_BYTES;

   logic                              present_ff;
   logic                              ram_en_ff, ram_en_in;
   logic [cbm_pkg::ROM_BANK_W-1:0]     rom_bank_ff, rom_bank_in;
   logic [cbm_pkg::RAM_BANK_W-1:0]     ram_bank_ff, ram_bank_in;
   logic                              mode_ff, mode_in;
   logic                              clr_busy_ff;
   logic [RAM_AW-1:0]                 clr_addr_ff;

   logic [cbm_pkg::REGION_W-1:0]       region;
   logic [cbm_pkg::RAM_BANK_W-1:0]     ram_bank_eff;
   logic [RAM_AW-1:0]                 ram_addr;
   logic [cbm_pkg::ROM_LOW_W-1:0]      low_bank;
   logic                              item_ram_wr;

   assign region       = bus_address[cbm_pkg::ADDR_W-1 -: cbm_pkg::REGION_W];
   assign ram_bank_eff = cbm_pkg::fold_ram_bank(ram_bank_ff, RAM_BANKS);
   assign ram_addr     = RAM_AW'({ram_bank_eff, bus_address[cbm_pkg::BANK_OFS_W-1:0]});
   assign low_bank     = (write_data[cbm_pkg::ROM_LOW_W-1:0] == '0) ?
                         cbm_pkg::ROM_LOW_W'(1) : write_data[cbm_pkg::ROM_LOW_W-1:0];

   always_comb begin
      decode      = '{target: cbm_pkg::TARGET_NONE, rom_address: '0, ram_rd: 1'b0};
      ram_en_in   = ram_en_ff;
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      mode_in     = mode_ff;
      item_ram_wr = 1'b0;
      if (!present_ff) begin
         if (func == cbm_pkg::FUNC_READ) begin
            decode.target      = cbm_pkg::TARGET_ROM;
            decode.rom_address = cbm_pkg::ROM_ADDR_W'(bus_address);
         end
      end else if (func == cbm_pkg::FUNC_READ) begin
         if (!bus_address[15]) begin
            decode.target = cbm_pkg::TARGET_ROM;
            if (bus_address[14]) begin
               decode.rom_address = {rom_bank_ff, bus_address[cbm_pkg::ROM_OFS_W-1:0]};
            end else begin
               decode.rom_address = cbm_pkg::ROM_ADDR_W'(bus_address);
            end
         end else if (region == cbm_pkg::REGION_RAM && ram_en_ff) begin
            decode.target = cbm_pkg::TARGET_RAM;
            decode.ram_rd = 1'b1;
         end
      end else begin
         unique case (region)
            cbm_pkg::REGION_RAM_ENABLE: begin
               ram_en_in = (write_data[3:0] == cbm_pkg::RAM_ENABLE_KEY);
            end
            cbm_pkg::REGION_ROM_BANK_LO: begin
               rom_bank_in = {rom_bank_ff[cbm_pkg::ROM_BANK_W-1:cbm_pkg::ROM_LOW_W], low_bank};
            end
            cbm_pkg::REGION_ROM_BANK_HI: begin
               if (mode_ff) begin
                  rom_bank_in = {write_data[1:0], rom_bank_ff[cbm_pkg::ROM_LOW_W-1:0]};
               end else begin
                  ram_bank_in = write_data[1:0];
               end
            end
            cbm_pkg::REGION_MODE: begin
               mode_in = !write_data[0];
            end
            cbm_pkg::REGION_RAM: begin
               if (ram_en_ff) begin
                  decode.target = cbm_pkg::TARGET_RAM;
                  item_ram_wr   = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= 1'b0;
         ram_en_ff   <= 1'b0;
         rom_bank_ff <= cbm_pkg::ROM_BANK_W'(1);
         ram_bank_ff <= '0;
         mode_ff     <= 1'b1;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            present_ff <= csr_wr_data;
         end
         if (accept) begin
            ram_en_ff   <= ram_en_in;
            rom_bank_ff <= rom_bank_in;
            ram_bank_ff <= ram_bank_in;
            mode_ff     <= mode_in;
         end
         // sweep zeros through the RAM once after reset
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + RAM_AW'(1);
            if (clr_addr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   assign clr_busy    = clr_busy_ff;
   assign ram_wr_en   = clr_busy_ff || (accept && item_ram_wr);
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : ram_addr;
   assign ram_wr_data = clr_busy_ff ? '0 : write_data;
   assign ram_rd_en   = accept && decode.ram_rd;
   assign ram_rd_addr = ram_addr;

endmodule

[hdl/cbm_resp.sv]
// RAM data alignment stage and output register of the response channel.
module cbm_resp (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  cbm_pkg::decode_type       decode,
   input  logic [cbm_pkg::DATA_W-1:0] ram_rd_data,
   output logic                      s1_free,
   cbm_rsp_if.source                 rsp
);

   logic                              s1_valid_ff;
   cbm_pkg::decode_type               s1_dec_ff;
   logic                              out_valid_ff;
   logic [cbm_pkg::TARGET_W-1:0]       out_target_ff;
   logic [cbm_pkg::ROM_ADDR_W-1:0]     out_rom_ff;
   logic [cbm_pkg::DATA_W-1:0]         out_data_ff;
   logic                              move;

   assign move    = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign s1_free = !s1_valid_ff || move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (move) begin
            s1_valid_ff <= 1'b0;
         end
         if (move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         s1_dec_ff <= decode;
      end
      // RAM read data arrives in the cycle after the access; join it here
      if (move) begin
         out_target_ff <= s1_dec_ff.target;
         out_rom_ff    <= s1_dec_ff.rom_address;
         out_data_ff   <= s1_dec_ff.ram_rd ? ram_rd_data : '0;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.target      = out_target_ff;
   assign rsp.rom_address = out_rom_ff;
   assign rsp.read_data   = out_data_ff;

endmodule

[hdl/cartridge_bank_mapper_core.sv]
// Cartridge bank mapper: one bus access in, one decoded result out.
//
// req_bus carries one CPU bus access per transaction (func, bus_address,
// write_data); rsp_bus returns one result per transaction (target,
// rom_address, read_data) in the same order. csr_wr_en/csr_wr_data set the
// controller-present bit; write it only while no transaction is in flight.
//
// Decode and RAM access take place as a request is accepted; the decoded
// result and the registered RAM read data then pass from the RAM stage into
// the output register, which drives the response. Unless req_bus.ready is
// held low, one transaction is taken per cycle; the RAM takes one access
// per cycle, and register updates apply to the very next transaction.
// After reset the block sweeps zeros through the RAM, one byte a cycle,
// over all RAM_BANKS * 8192 bytes (32768 at the default); req_bus.ready
// stays low during the sweep, configuration writes are taken throughout.
// If the receiver stalls, the response waits in the output register and one
// more transaction is taken into the RAM stage before req_bus.ready drops.
module cartridge_bank_mapper_core #(
   parameter int RAM_BANKS = cbm_pkg::RAM_BANKS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cbm_req_if.sink   req_bus,
   cbm_rsp_if.source rsp_bus,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   localparam int RAM_DEPTH = RAM_BANKS * cbm_pkg::RAM_BANK_BYTES;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   logic                         accept;
   logic                         s1_free;
   logic                         clr_busy;
   cbm_pkg::decode_type          decode;
   logic                         ram_wr_en;
   logic [RAM_AW-1:0]            ram_wr_addr;
   logic [cbm_pkg::DATA_W-1:0]    ram_wr_data;
   logic                         ram_rd_en;
   logic [RAM_AW-1:0]            ram_rd_addr;
   logic [cbm_pkg::DATA_W-1:0]    ram_rd_data;

   assign req_bus.ready = s1_free && !clr_busy;
   assign accept        = req_bus.valid && req_bus.ready;

   cbm_ctrl #(
      .RAM_BANKS (RAM_BANKS),
      .RAM_AW    (RAM_AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .func        (req_bus.func),
      .bus_address (req_bus.bus_address),
      .write_data  (req_bus.write_data),
      .decode      (decode),
      .clr_busy    (clr_busy),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr)
   );

   cbm_ram #(
      .WIDTH (cbm_pkg::DATA_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cbm_resp u_resp (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .decode      (decode),
      .ram_rd_data (ram_rd_data),
      .s1_free     (s1_free),
      .rsp         (rsp_bus)
   );

endmodule

[hdl/cbm_checker.sv]
// Port-level checker of the cartridge bank mapper and its bind.
module cbm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cbm_pkg::TARGET_W-1:0]   rsp_target,
   input logic [cbm_pkg::ROM_ADDR_W-1:0] rsp_rom_address,
   input logic [cbm_pkg::DATA_W-1:0]     rsp_read_data,
   input logic                           csr_wr_en,
   input logic                           csr_wr_data
);

   // response must hold while the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_target) && $stable(rsp_rom_address)
         && $stable(rsp_read_data))
      else $error("response changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid && !req_ready)
      else $error("channel active right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target != cbm_pkg::TARGET_ROM |-> rsp_rom_address == '0)
      else $error("ROM address set on a non-ROM result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target != cbm_pkg::TARGET_RAM |-> rsp_read_data == '0)
      else $error("read data set on a non-RAM result");

   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en && !csr_wr_data |=> !rsp_valid || rsp_target != cbm_pkg::TARGET_RAM
         || $past(rsp_valid))
      else $error("RAM result without a pending transaction");

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_target      (rsp_bus.target),
   .rsp_rom_address (rsp_bus.rom_address),
   .rsp_read_data   (rsp_bus.read_data),
   .csr_wr_en       (csr_wr_en),
   .csr_wr_data     (csr_wr_data)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the cartridge bank mapper core.
module tb_top;
   import cbm_pkg::*;

   localparam int       RAM_BANK_COUNT = RAM_BANKS_DEF;
   localparam int       RAM_BYTES      = RAM_BANK_COUNT * RAM_BANK_BYTES;
   localparam int       CYCLE_LIMIT    = 300000;
   localparam int       PHASES         = 8;
   localparam int       PHASE_ITEMS    = 210;

   typedef struct packed {
      logic [TARGET_W-1:0]   target;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic [DATA_W-1:0]     read_data;
   } map_result_type;

   class mapper_scoreboard;
      bit                    present;
      bit                    ram_on;
      logic [ROM_BANK_W-1:0] rom_bank;
      logic [RAM_BANK_W-1:0] ram_bank;
      bit                    rom_mode;
      logic [DATA_W-1:0]     ram_bytes [RAM_BYTES];
      map_result_type        pending_decodes[$];
      int                    mismatches;

      function new();
         present    = 1'b0;
         ram_on     = 1'b0;
         rom_bank   = 7'd1;
         ram_bank   = 2'd0;
         rom_mode   = 1'b1;
         mismatches = 0;
         foreach (ram_bytes[i]) ram_bytes[i] = '0;
      endfunction

      function void set_present(logic v);
         present = v;
      endfunction

      function int pending();
         return pending_decodes.size();
      endfunction

      // Decode one accepted access and queue the result it should produce.
      function void note_access(logic f, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
         map_result_type res;
         int             idx;
         logic [4:0]     low;
         res = '0;
         idx = (int'(ram_bank) % RAM_BANK_COUNT) * RAM_BANK_BYTES + int'(a[BANK_OFS_W-1:0]);
         if (!present) begin
            if (f == FUNC_READ) begin
               res.target      = TARGET_ROM;
               res.rom_address = ROM_ADDR_W'(a);
            end
         end else if (f == FUNC_READ) begin
            case (a[15:13])
               REGION_RAM_ENABLE, REGION_ROM_BANK_LO: begin
                  res.target      = TARGET_ROM;
                  res.rom_address = ROM_ADDR_W'(a);
               end
               REGION_ROM_BANK_HI, REGION_MODE: begin
                  res.target      = TARGET_ROM;
                  res.rom_address = {rom_bank, a[ROM_OFS_W-1:0]};
               end
               REGION_RAM: begin
                  if (ram_on) begin
                     res.target    = TARGET_RAM;
                     res.read_data = ram_bytes[idx];
                  end
               end
               default: ;
            endcase
         end else begin
            case (a[15:13])
               REGION_RAM_ENABLE: ram_on = (d[3:0] == RAM_ENABLE_KEY);
               REGION_ROM_BANK_LO: begin
                  low = d[4:0];
                  // a zero in the low bank bits is read as 1
                  if (low == 5'd0) low = 5'd1;
                  rom_bank = {rom_bank[6:5], low};
               end
               REGION_ROM_BANK_HI: begin
                  if (rom_mode) rom_bank = {d[1:0], rom_bank[4:0]};
                  else ram_bank = d[1:0];
               end
               REGION_MODE: rom_mode = (d[0] == 1'b0);
               REGION_RAM: begin
                  if (ram_on) begin
                     ram_bytes[idx] = d;
                     res.target     = TARGET_RAM;
                  end
               end
               default: ;
            endcase
         end
         pending_decodes.push_back(res);
      endfunction

      function void check_result(map_result_type got);
         map_result_type exp;
         if (pending_decodes.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response: target %0d rom_address %h read_data %h",
                        got.target, got.rom_address, got.read_data);
            mismatches++;
            return;
         end
         exp = pending_decodes.pop_front();
         if (got.target !== exp.target || got.rom_address !== exp.rom_address ||
             got.read_data !== exp.read_data) begin
            if (mismatches < 10)
               $display("mismatch: expected target %0d rom_address %h read_data %h, got %0d %h %h",
                        exp.target, exp.rom_address, exp.read_data,
                        got.target, got.rom_address, got.read_data);
            mismatches++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic             csr_wr_data;
   logic             hold_rsp;
   int               cycles;
   int               send_idle_pct;
   int               rsp_stall_pct;
   mapper_scoreboard sb;

   cbm_req_if req_bus ();
   cbm_rsp_if rsp_bus ();

   cartridge_bank_mapper_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_top failed");
      $finish;
   end

   // Response side: check each transaction, then pick ready for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result({rsp_bus.target, rsp_bus.rom_address, rsp_bus.read_data});
      rsp_bus.ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_access(input logic f, input logic [ADDR_W-1:0] a,
                              input logic [DATA_W-1:0] d);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= f;
      req_bus.bus_address <= a;
      req_bus.write_data  <= d;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_access(f, a, d);
   endtask

   // Drop valid, let every response arrive, then allow the pipeline to settle.
   task automatic drain_responses();
      if (req_bus.valid) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_present(input logic v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.set_present(v);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [BANK_OFS_W-1:0] pick_ram_offset();
      int r;
      r = $urandom_range(3);
      // keep half the accesses on a few hot bytes so reads see earlier writes
      if (r == 0) return BANK_OFS_W'($urandom_range(15));
      if (r == 1) return 13'h1FF0 + BANK_OFS_W'($urandom_range(15));
      return BANK_OFS_W'($urandom);
   endfunction

   initial begin
      logic              f;
      logic [ADDR_W-1:0] a;
      logic [DATA_W-1:0] d;
      int                r;
      bit                plan [PHASES];

      plan = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      sb                  = new();
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= 1'b0;
      hold_rsp            <= 1'b0;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= FUNC_READ;
      req_bus.bus_address <= '0;
      req_bus.write_data  <= '0;
      send_idle_pct       = 0;
      rsp_stall_pct       = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // ROM-only cartridge
      write_present(1'b0);
      send_access(FUNC_READ, 16'h0000, 8'h00);
      send_access(FUNC_READ, 16'hFFFF, 8'hFF);
      send_access(FUNC_WRITE, 16'h2000, 8'h00);
      send_access(FUNC_WRITE, 16'hA000, 8'h55);
      send_access(FUNC_READ, 16'h7FFF, 8'h00);
      drain_responses();

      // bank controller fitted
      write_present(1'b1);
      send_access(FUNC_READ, 16'h0000, 8'h00);
      send_access(FUNC_READ, 16'h3FFF, 8'h00);
      send_access(FUNC_READ, 16'h4000, 8'h00);
      send_access(FUNC_READ, 16'hA000, 8'h00);
      send_access(FUNC_WRITE, 16'hA000, 8'h77);
      send_access(FUNC_WRITE, 16'h1FFF, 8'hFA);
      send_access(FUNC_WRITE, 16'h2000, 8'h00);
      send_access(FUNC_READ, 16'h7FFF, 8'h00);
      send_access(FUNC_WRITE, 16'h3FFF, 8'hFF);
      send_access(FUNC_WRITE, 16'h4000, 8'h03);
      send_access(FUNC_READ, 16'h7FFF, 8'h00);
      send_access(FUNC_WRITE, 16'h6000, 8'h01);
      send_access(FUNC_WRITE, 16'h5FFF, 8'h02);
      send_access(FUNC_READ, 16'h4000, 8'h00);
      send_access(FUNC_WRITE, 16'hBFFF, 8'hFF);
      send_access(FUNC_READ, 16'hBFFF, 8'h00);
      send_access(FUNC_READ, 16'h8000, 8'h00);
      send_access(FUNC_WRITE, 16'hC000, 8'hAA);
      send_access(FUNC_READ, 16'hFFFF, 8'h00);
      send_access(FUNC_WRITE, 16'h0000, 8'h00);
      send_access(FUNC_READ, 16'hBFFF, 8'h00);
      send_access(FUNC_WRITE, 16'h7FFF, 8'hFE);
      drain_responses();

      for (int p = 0; p < PHASES; p++) begin
         write_present(plan[p]);
         send_idle_pct = (p % 4 == 1) ? 52 : (p % 4 == 3) ? 32 : 0;
         rsp_stall_pct = (p % 4 == 2) ? 52 : (p % 4 == 3) ? 32 : 0;
         if (p == 4) begin
            // hold the response side off long enough for the input to back up
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (400) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            d = DATA_W'($urandom);
            f = FUNC_WRITE;
            if (r < 10) begin
               a = {3'b000, 13'($urandom)};
               if ($urandom_range(9) < 7) d[3:0] = RAM_ENABLE_KEY;
            end else if (r < 20) begin
               a = {3'b001, 13'($urandom)};
               if ($urandom_range(6) == 0) d[4:0] = 5'd0;
            end else if (r < 28) begin
               a = {3'b010, 13'($urandom)};
            end else if (r < 33) begin
               a = {3'b011, 13'($urandom)};
            end else if (r < 50) begin
               a = {3'b101, pick_ram_offset()};
            end else if (r < 70) begin
               f = FUNC_READ;
               a = {3'b101, pick_ram_offset()};
            end else if (r < 85) begin
               f = FUNC_READ;
               a = {1'b0, 15'($urandom)};
            end else if (r < 93) begin
               f = 1'($urandom);
               a = $urandom_range(1) ? {3'b100, 13'($urandom)} : 16'($urandom_range(16'hC000, 16'hFFFF));
            end else begin
               f = 1'($urandom);
               a = ADDR_W'($urandom);
            end
            send_access(f, a, d);
         end
         drain_responses();
      end

      hold_rsp <= 1'b0;
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

[filelist.f]
hdl/cbm_pkg.sv
hdl/cbm_if.sv
hdl/cbm_ram.sv
hdl/cbm_ctrl.sv
hdl/cbm_resp.sv
hdl/cartridge_bank_mapper_core.sv
hdl/cbm_checker.sv
tb/sv/tb_top.sv
